// ----- rtl/core/htsp_pkg.sv -----
// Shared types, codes and constants for the humidity and temperature sensor poller.
`default_nettype none

package htsp_pkg;

  // Mode codes
  localparam logic [1:0] MODE_UNAVAIL = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_MEASURE = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_WAIT  = 2'd0;
  localparam logic [1:0] ACT_INIT  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Register indexes and reset values
  localparam logic [1:0] REG_RETRY   = 2'd0;
  localparam logic [1:0] REG_MEASURE = 2'd1;
  localparam logic [1:0] REG_CONV    = 2'd2;

  localparam logic [15:0] RETRY_RST   = 16'd5000;
  localparam logic [15:0] MEASURE_RST = 16'd2000;
  localparam logic [15:0] CONV_RST    = 16'd80;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Status byte bits
  localparam int unsigned STATUS_BUSY_BIT  = 7;
  localparam int unsigned STATUS_CALIB_BIT = 3;

  // Frame scaling
  localparam int unsigned RAW_W       = 20;
  localparam logic [9:0]  HUMID_SCALE = 10'd1000;
  localparam logic [10:0] TEMP_SCALE  = 11'd2000;
  localparam logic [30:0] RAW_HALF    = 31'd524288;
  localparam logic [10:0] HUMID_MAX   = 11'd1000;
  localparam logic [11:0] TEMP_OFFSET = 12'd500;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        init_ack;
    logic [7:0]  init_status;
    logic        start_ack;
    logic        read_ok;
    logic [47:0] frame;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        mode_now;
    logic              available;
    logic              reading_valid;
    logic signed [11:0] temperature_c10;
    logic [9:0]        humidity_pct10;
  } out_beat_t;

  typedef struct packed {
    logic signed [11:0] temp;
    logic [9:0]         humid;
  } reading_t;

endpackage

`default_nettype wire

// ----- rtl/core/htsp_conv.sv -----
// Frame to reading conversion: split raw fields, scale with rounding, clamp humidity.
`default_nettype none

module htsp_conv (
  input  wire logic [47:0]       frame,
  output htsp_pkg::reading_t     reading
);

  logic [htsp_pkg::RAW_W-1:0] raw_h;
  logic [htsp_pkg::RAW_W-1:0] raw_t;
  logic [30:0] prod_h;
  logic [30:0] prod_t;
  logic [30:0] sum_h;
  logic [30:0] sum_t;
  logic [10:0] h;
  logic [10:0] t;

  assign raw_h = frame[39:20];
  assign raw_t = frame[19:0];

  // Scale to tenths, round to nearest
  assign prod_h = 31'(raw_h) * 31'(htsp_pkg::HUMID_SCALE);
  assign prod_t = 31'(raw_t) * 31'(htsp_pkg::TEMP_SCALE);
  assign sum_h  = prod_h + htsp_pkg::RAW_HALF;
  assign sum_t  = prod_t + htsp_pkg::RAW_HALF;
  assign h      = sum_h[30:20];
  assign t      = sum_t[30:20];

  always_comb begin
    reading.humid = (h > htsp_pkg::HUMID_MAX) ? htsp_pkg::HUMID_MAX[9:0] : h[9:0];
    reading.temp  = $signed({1'b0, t} - htsp_pkg::TEMP_OFFSET);
  end

endmodule

`default_nettype wire

// ----- rtl/core/humidity_temp_sensor_poller.sv -----
// Top level: poll handling state machine, register file and result staging.
// A poll accepted sits in the input register; its result is loaded into the output
//   register when the held poll advances (out_valid from then on).
// Throughput: one poll per cycle; the input register drains whenever the output
//   register is empty or being taken, so in_ready only drops on output stall.
// Reset (rst_n low, synchronous): mode unavailable, stamps and readings zero,
//   registers at 5000/2000/80 ms, both stages empty.
`default_nettype none

module humidity_temp_sensor_poller (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // poll channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire htsp_pkg::in_beat_t                in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output htsp_pkg::out_beat_t                    out_data,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [htsp_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [htsp_pkg::DATA_W-1:0]       pwdata,
  output logic [htsp_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] retry_ms_r;
  logic [15:0] measure_ms_r;
  logic [15:0] conv_ms_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_ms_r   <= htsp_pkg::RETRY_RST;
      measure_ms_r <= htsp_pkg::MEASURE_RST;
      conv_ms_r    <= htsp_pkg::CONV_RST;
    end else if (cfg_wr) begin
      // index beyond the list: drop the write
      unique case (cfg_idx)
        htsp_pkg::REG_RETRY:   retry_ms_r   <= pwdata[15:0];
        htsp_pkg::REG_MEASURE: measure_ms_r <= pwdata[15:0];
        htsp_pkg::REG_CONV:    conv_ms_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      htsp_pkg::REG_RETRY:   prdata = {16'd0, retry_ms_r};
      htsp_pkg::REG_MEASURE: prdata = {16'd0, measure_ms_r};
      htsp_pkg::REG_CONV:    prdata = {16'd0, conv_ms_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register and handshake
  // ---------------------------------------------------------------------
  logic               s1_valid_r;
  htsp_pkg::in_beat_t s1_beat_r;
  logic               s1_go;
  logic               out_valid_r;
  htsp_pkg::out_beat_t out_beat_r;

  // The held poll moves on when the result register is free or being taken.
  assign s1_go    = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      s1_beat_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Poll state: mode, wrapping stamps, latest reading and flags
  // ---------------------------------------------------------------------
  logic [1:0]  mode_r,        mode_nxt;
  logic [31:0] start_stamp_r, start_stamp_nxt;
  logic [31:0] retry_stamp_r, retry_stamp_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  logic [9:0]  humid_r,       humid_nxt;
  logic        avail_r,       avail_nxt;
  logic        rvalid_r,      rvalid_nxt;
  logic [1:0]  action;

  logic [31:0] since_start;
  logic [31:0] since_retry;
  logic        measure_due;
  logic        conv_due;
  logic        retry_due;
  logic        frame_good;
  logic        init_good;
  htsp_pkg::reading_t reading;

  htsp_conv u_conv (
    .frame   (s1_beat_r.frame),
    .reading (reading)
  );

  // Elapsed time uses the wrapping 32-bit difference.
  assign since_start = s1_beat_r.now_ms - start_stamp_r;
  assign since_retry = s1_beat_r.now_ms - retry_stamp_r;
  assign measure_due = since_start >= {16'd0, measure_ms_r};
  assign conv_due    = since_start >= {16'd0, conv_ms_r};
  assign retry_due   = since_retry >= {16'd0, retry_ms_r};

  // A busy status byte counts as a failed read.
  assign frame_good = s1_beat_r.read_ok &
                      ~s1_beat_r.frame[40 + htsp_pkg::STATUS_BUSY_BIT];
  assign init_good  = s1_beat_r.init_ack &
                      s1_beat_r.init_status[htsp_pkg::STATUS_CALIB_BIT];

  always_comb begin
    mode_nxt        = mode_r;
    start_stamp_nxt = start_stamp_r;
    retry_stamp_nxt = retry_stamp_r;
    temp_nxt        = temp_r;
    humid_nxt       = humid_r;
    avail_nxt       = avail_r;
    rvalid_nxt      = rvalid_r;
    action          = htsp_pkg::ACT_WAIT;
    unique case (mode_r)
      htsp_pkg::MODE_IDLE: begin
        if (measure_due) begin
          action = htsp_pkg::ACT_START;
          if (s1_beat_r.start_ack) begin
            start_stamp_nxt = s1_beat_r.now_ms;
            mode_nxt        = htsp_pkg::MODE_MEASURE;
          end else begin
            // trigger refused: drop to unavailable
            avail_nxt       = 1'b0;
            rvalid_nxt      = 1'b0;
            mode_nxt        = htsp_pkg::MODE_UNAVAIL;
            retry_stamp_nxt = s1_beat_r.now_ms;
          end
        end
      end
      htsp_pkg::MODE_MEASURE: begin
        if (conv_due) begin
          action = htsp_pkg::ACT_READ;
          if (frame_good) begin
            temp_nxt   = reading.temp;
            humid_nxt  = reading.humid;
            avail_nxt  = 1'b1;
            rvalid_nxt = 1'b1;
            mode_nxt   = htsp_pkg::MODE_IDLE;
          end else begin
            // failed or busy read: drop, keep the old reading on show
            avail_nxt       = 1'b0;
            rvalid_nxt      = 1'b0;
            mode_nxt        = htsp_pkg::MODE_UNAVAIL;
            retry_stamp_nxt = s1_beat_r.now_ms;
          end
        end
      end
      default: begin
        // unavailable, and the unused code treated the same way
        mode_nxt = htsp_pkg::MODE_UNAVAIL;
        if (retry_due) begin
          action = htsp_pkg::ACT_INIT;
          // a failed attempt leaves retry_stamp alone, so retry on every poll
          if (init_good) begin
            avail_nxt  = 1'b1;
            rvalid_nxt = 1'b0;
            mode_nxt   = htsp_pkg::MODE_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= htsp_pkg::MODE_UNAVAIL;
      start_stamp_r <= '0;
      retry_stamp_r <= '0;
      temp_r        <= '0;
      humid_r       <= '0;
      avail_r       <= 1'b0;
      rvalid_r      <= 1'b0;
    end else if (s1_go) begin
      mode_r        <= mode_nxt;
      start_stamp_r <= start_stamp_nxt;
      retry_stamp_r <= retry_stamp_nxt;
      temp_r        <= temp_nxt;
      humid_r       <= humid_nxt;
      avail_r       <= avail_nxt;
      rvalid_r      <= rvalid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold until taken, load as the held poll advances
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_beat_r.action          <= action;
      out_beat_r.mode_now        <= mode_nxt;
      out_beat_r.available       <= avail_nxt;
      out_beat_r.reading_valid   <= rvalid_nxt;
      out_beat_r.temperature_c10 <= temp_nxt;
      out_beat_r.humidity_pct10  <= humid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule

`default_nettype wire

// ----- rtl/core/htsp_chk.sv -----
// Port-level checker for the poller, bound to the top level.
`default_nettype none

module htsp_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire htsp_pkg::out_beat_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // Available exactly when the mode is idle or measuring.
  a_avail_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.available == (out_data.mode_now != htsp_pkg::MODE_UNAVAIL)))
    else $error("available disagrees with mode");

  // A valid reading needs a usable sensor.
  a_valid_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_valid |-> out_data.available)
    else $error("reading valid while unavailable");

  // A read that lands in idle has just delivered a reading.
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == htsp_pkg::ACT_READ &&
    out_data.mode_now == htsp_pkg::MODE_IDLE |-> out_data.reading_valid)
    else $error("successful read without valid reading");

  // Humidity never passes its clamp.
  a_humid_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_pct10 <= htsp_pkg::HUMID_MAX[9:0])
    else $error("humidity above clamp");

endmodule

bind humidity_temp_sensor_poller htsp_chk u_htsp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the humidity and temperature sensor poller.
`timescale 1ns / 100ps

module tb_top;

  // The register map has one spare slot past the last register; writes there go nowhere.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned DRAIN_TICKS  = 8;
  localparam int unsigned PHASE_POLLS  = 240;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  htsp_pkg::in_beat_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  htsp_pkg::out_beat_t           out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [htsp_pkg::ADDR_W-1:0]   paddr = '0;
  logic [htsp_pkg::DATA_W-1:0]   pwdata = '0;
  logic [htsp_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  humidity_temp_sensor_poller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns period: 6 ns low, 6 ns high.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the poller: interval settings, mode, both time stamps and
  // the held reading. Advanced once for every poll the block accepts.
  // ---------------------------------------------------------------------------
  logic [15:0] retry_ms;
  logic [15:0] measure_ms;
  logic [15:0] conv_ms;
  logic [1:0]  sensor_mode;
  logic [31:0] start_stamp_ms;
  logic [31:0] retry_stamp_ms;
  logic [11:0] held_temp;
  logic [9:0]  held_humid;
  logic        sensor_avail;
  logic        reading_held;

  // Expected results, oldest first.
  htsp_pkg::out_beat_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle odds per side (percent of cycles) and the receiver's hold-off count.
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 35;
  int unsigned hold_left = 0;

  // Running poll time for well-formed stimulus.
  logic [31:0] poll_clock_ms = '0;

  htsp_pkg::out_beat_t oldest_result;

  function automatic void reset_sensor_model();
    retry_ms       = htsp_pkg::RETRY_RST;
    measure_ms     = htsp_pkg::MEASURE_RST;
    conv_ms        = htsp_pkg::CONV_RST;
    sensor_mode    = htsp_pkg::MODE_UNAVAIL;
    start_stamp_ms = '0;
    retry_stamp_ms = '0;
    held_temp      = '0;
    held_humid     = '0;
    sensor_avail   = 1'b0;
    reading_held   = 1'b0;
  endfunction

  // A refused start or a failed read: drop availability and restart the retry clock.
  function automatic void lose_sensor(input logic [31:0] now_ms);
    sensor_avail   = 1'b0;
    reading_held   = 1'b0;
    sensor_mode    = htsp_pkg::MODE_UNAVAIL;
    retry_stamp_ms = now_ms;
  endfunction

  // Advance the shadow state by one poll and return the result it yields.
  function automatic htsp_pkg::out_beat_t predict_poll(input htsp_pkg::in_beat_t poll);
    htsp_pkg::out_beat_t res;
    logic [31:0] since_start;
    logic [31:0] since_retry;
    logic [63:0] raw_humid;
    logic [63:0] raw_temp;
    logic [63:0] humid_scaled;
    logic [63:0] temp_scaled;
    since_start = poll.now_ms - start_stamp_ms;
    since_retry = poll.now_ms - retry_stamp_ms;
    res.action  = htsp_pkg::ACT_WAIT;
    case (sensor_mode)
      htsp_pkg::MODE_IDLE: begin
        if (since_start >= {16'd0, measure_ms}) begin
          res.action = htsp_pkg::ACT_START;
          if (poll.start_ack) begin
            start_stamp_ms = poll.now_ms;
            sensor_mode    = htsp_pkg::MODE_MEASURE;
          end else begin
            lose_sensor(poll.now_ms);
          end
        end
      end
      htsp_pkg::MODE_MEASURE: begin
        if (since_start >= {16'd0, conv_ms}) begin
          res.action = htsp_pkg::ACT_READ;
          if (poll.read_ok && !poll.frame[40 + htsp_pkg::STATUS_BUSY_BIT]) begin
            // Humidity in bits 39..20, temperature in bits 19..0, both 20-bit raw.
            raw_humid    = poll.frame[39:20];
            raw_temp     = poll.frame[19:0];
            humid_scaled = (raw_humid * htsp_pkg::HUMID_SCALE + htsp_pkg::RAW_HALF)
                           >> htsp_pkg::RAW_W;
            temp_scaled  = (raw_temp * htsp_pkg::TEMP_SCALE + htsp_pkg::RAW_HALF)
                           >> htsp_pkg::RAW_W;
            if (humid_scaled > htsp_pkg::HUMID_MAX) begin
              humid_scaled = htsp_pkg::HUMID_MAX;
            end
            held_humid   = humid_scaled[9:0];
            held_temp    = temp_scaled[11:0] - htsp_pkg::TEMP_OFFSET;
            sensor_avail = 1'b1;
            reading_held = 1'b1;
            sensor_mode  = htsp_pkg::MODE_IDLE;
          end else begin
            lose_sensor(poll.now_ms);
          end
        end
      end
      default: begin
        sensor_mode = htsp_pkg::MODE_UNAVAIL;
        if (since_retry >= {16'd0, retry_ms}) begin
          res.action = htsp_pkg::ACT_INIT;
          // A failed attempt keeps the old retry stamp, so it retries every poll.
          if (poll.init_ack && poll.init_status[htsp_pkg::STATUS_CALIB_BIT]) begin
            sensor_avail = 1'b1;
            reading_held = 1'b0;
            sensor_mode  = htsp_pkg::MODE_IDLE;
          end
        end
      end
    endcase
    res.mode_now        = sensor_mode;
    res.available       = sensor_avail;
    res.reading_valid   = reading_held;
    res.temperature_c10 = held_temp;
    res.humidity_pct10  = held_humid;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Poll sender: random idle cycles, then hold the beat until it is taken.
  // ---------------------------------------------------------------------------
  task automatic send_poll(input htsp_pkg::in_beat_t poll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= poll;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_results.push_back(predict_poll(poll));
  endtask

  task automatic offer_poll(input logic [31:0] now_ms, input logic init_ack,
                            input logic [7:0] status, input logic start_ack,
                            input logic read_ok, input logic [47:0] frame);
    htsp_pkg::in_beat_t poll;
    poll.now_ms      = now_ms;
    poll.init_ack    = init_ack;
    poll.init_status = status;
    poll.start_ack   = start_ack;
    poll.read_ok     = read_ok;
    poll.frame       = frame;
    send_poll(poll);
  endtask

  // Mostly well-formed polls: time moves forward a little and the bus mostly
  // answers. Now and then time jumps anywhere, which also exercises wrap-around.
  function automatic htsp_pkg::in_beat_t random_poll(input int unsigned max_step);
    htsp_pkg::in_beat_t poll;
    if ($urandom_range(99) < 8) begin
      poll_clock_ms = $urandom();
    end else begin
      poll_clock_ms = poll_clock_ms + $urandom_range(max_step);
    end
    poll.now_ms      = poll_clock_ms;
    poll.init_ack    = ($urandom_range(99) < 90);
    poll.init_status = 8'($urandom());
    if ($urandom_range(99) < 85) begin
      poll.init_status[htsp_pkg::STATUS_CALIB_BIT] = 1'b1;
    end
    poll.start_ack   = ($urandom_range(99) < 90);
    poll.read_ok     = ($urandom_range(99) < 90);
    poll.frame[47:32] = 16'($urandom());
    poll.frame[31:0]  = $urandom();
    if ($urandom_range(99) < 90) begin
      poll.frame[40 + htsp_pkg::STATUS_BUSY_BIT] = 1'b0;
    end
    return poll;
  endfunction

  // Drop valid and wait until every result is back, plus a short pause.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register access: setup cycle, access cycle, then idle.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      htsp_pkg::REG_RETRY:   retry_ms   = value;
      htsp_pkg::REG_MEASURE: measure_ms = value;
      htsp_pkg::REG_CONV:    conv_ms    = value;
      default:               ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    // Read data is stable in the middle of the access cycle.
    @(negedge clk);
    if (prdata !== {16'd0, value}) begin
      $error("register %0d: expected %0d, got %0d", idx, value, prdata);
      error_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result beat with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no poll pending: action %0d mode %0d",
               out_data.action, out_data.mode_now);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data.action !== oldest_result.action) begin
          $error("action: expected %0d, got %0d", oldest_result.action, out_data.action);
          error_count++;
        end
        if (out_data.mode_now !== oldest_result.mode_now) begin
          $error("mode_now: expected %0d, got %0d", oldest_result.mode_now,
                 out_data.mode_now);
          error_count++;
        end
        if (out_data.available !== oldest_result.available) begin
          $error("available: expected %0d, got %0d", oldest_result.available,
                 out_data.available);
          error_count++;
        end
        if (out_data.reading_valid !== oldest_result.reading_valid) begin
          $error("reading_valid: expected %0d, got %0d", oldest_result.reading_valid,
                 out_data.reading_valid);
          error_count++;
        end
        if (out_data.temperature_c10 !== oldest_result.temperature_c10) begin
          $error("temperature_c10: expected %0d, got %0d", oldest_result.temperature_c10,
                 out_data.temperature_c10);
          error_count++;
        end
        if (out_data.humidity_pct10 !== oldest_result.humidity_pct10) begin
          $error("humidity_pct10: expected %0d, got %0d", oldest_result.humidity_pct10,
                 out_data.humidity_pct10);
          error_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come out of reset at their documented defaults.
  task automatic test_register_defaults();
    check_reg(htsp_pkg::REG_RETRY, htsp_pkg::RETRY_RST);
    check_reg(htsp_pkg::REG_MEASURE, htsp_pkg::MEASURE_RST);
    check_reg(htsp_pkg::REG_CONV, htsp_pkg::CONV_RST);
  endtask

  // Walk the mode machine by hand with the default intervals: start-up wait,
  // failed and uncalibrated init, refused start, early and late reads, frame
  // extremes, busy frame, lost frame, stale readings and time wrap-around.
  task automatic test_poll_sequence();
    // Start-up: nothing until the retry interval has passed since time zero.
    offer_poll(32'd0,     1'b1, 8'h08, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
    offer_poll(32'd4999,  1'b1, 8'hFF, 1'b1, 1'b1, 48'h0);
    // Failed init: no ack, then ack without calibration; both retry at once.
    offer_poll(32'd5000,  1'b0, 8'hFF, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd5001,  1'b1, 8'hF7, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd5002,  1'b1, 8'h08, 1'b0, 1'b0, 48'h0);
    // Start stamp is still zero, so a start is due; refuse it.
    offer_poll(32'd5003,  1'b1, 8'h08, 1'b0, 1'b1, 48'h0);
    offer_poll(32'd5004,  1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd10003, 1'b1, 8'h08, 1'b0, 1'b0, 48'h0);
    offer_poll(32'd10004, 1'b0, 8'h00, 1'b1, 1'b0, 48'h0);
    // One ms short of the conversion delay, then the full-scale frame.
    offer_poll(32'd10083, 1'b1, 8'h08, 1'b1, 1'b1, 48'h7FFF_FFFF_FFFF);
    offer_poll(32'd10084, 1'b0, 8'h00, 1'b0, 1'b1, 48'h7FFF_FFFF_FFFF);
    offer_poll(32'd12003, 1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd12004, 1'b0, 8'h00, 1'b1, 1'b0, 48'h0);
    // All-zero frame: lowest temperature, zero humidity.
    offer_poll(32'd12084, 1'b0, 8'h00, 1'b0, 1'b1, 48'h0);
    offer_poll(32'd14004, 1'b0, 8'h00, 1'b1, 1'b0, 48'h0);
    // Busy frame counts as a failed read; readings stay as they were.
    offer_poll(32'd14084, 1'b1, 8'h08, 1'b1, 1'b1, 48'h8012_3456_789A);
    offer_poll(32'd19084, 1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd19085, 1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    // Lost frame bytes.
    offer_poll(32'd19165, 1'b1, 8'h08, 1'b1, 1'b0, 48'h0012_3456_789A);
    // Wrap-around: stamps near the top, elapsed time counted modulo 2^32.
    offer_poll(32'hFFFF_F000, 1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    offer_poll(32'hFFFF_FFFF, 1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    offer_poll(32'd78,    1'b1, 8'h08, 1'b1, 1'b1, 48'h1C6B_5A3E_9107);
    offer_poll(32'd79,    1'b1, 8'h08, 1'b1, 1'b1, 48'h1C6B_5A3E_9107);
    offer_poll(32'd1998,  1'b1, 8'h08, 1'b1, 1'b1, 48'h0);
    settle_block();
    poll_clock_ms = 32'd1998;
  endtask

  // Write every register, read it back, and check the spare slot changes nothing.
  task automatic test_register_writes();
    write_reg(htsp_pkg::REG_RETRY, 16'hFFFF);
    write_reg(htsp_pkg::REG_MEASURE, 16'h0000);
    write_reg(htsp_pkg::REG_CONV, 16'hA5C3);
    write_reg(REG_SPARE, 16'h1234);
    check_reg(htsp_pkg::REG_RETRY, retry_ms);
    check_reg(htsp_pkg::REG_MEASURE, measure_ms);
    check_reg(htsp_pkg::REG_CONV, conv_ms);
    write_reg(htsp_pkg::REG_RETRY, htsp_pkg::RETRY_RST);
    write_reg(htsp_pkg::REG_MEASURE, htsp_pkg::MEASURE_RST);
    write_reg(htsp_pkg::REG_CONV, htsp_pkg::CONV_RST);
  endtask

  // Hold the result side off while polls keep coming, so the input stalls.
  task automatic test_result_backpressure();
    write_reg(htsp_pkg::REG_RETRY, 16'd3);
    write_reg(htsp_pkg::REG_MEASURE, 16'd5);
    write_reg(htsp_pkg::REG_CONV, 16'd2);
    send_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    repeat (30) send_poll(random_poll(4));
    send_idle_pct = 35;
    settle_block();
  endtask

  // One phase of random polls under one register setting.
  task automatic run_poll_phase(input logic [15:0] retry, input logic [15:0] measure,
                                input logic [15:0] conv, input int unsigned max_step,
                                input int unsigned idle_pct);
    settle_block();
    write_reg(htsp_pkg::REG_RETRY, retry);
    write_reg(htsp_pkg::REG_MEASURE, measure);
    write_reg(htsp_pkg::REG_CONV, conv);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    repeat (PHASE_POLLS) send_poll(random_poll(max_step));
  endtask

  task automatic test_random_polls();
    // Zero intervals: every poll acts.
    run_poll_phase(16'd0, 16'd0, 16'd0, 3, 35);
    // Largest intervals: big time steps to get past them.
    run_poll_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40000, 35);
    repeat (3) begin
      run_poll_phase(16'($urandom_range(60)), 16'($urandom_range(60)),
                     16'($urandom_range(30)), 40, 35);
    end
    // Long stretch with no idling on either side.
    run_poll_phase(16'($urandom_range(20)), 16'($urandom_range(30)),
                   16'($urandom_range(15)), 20, 0);
    send_idle_pct = 35;
    recv_idle_pct = 35;
    settle_block();
  endtask

  initial begin
    reset_sensor_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_poll_sequence();
    test_register_writes();
    test_result_backpressure();
    test_random_polls();

    repeat (DRAIN_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
